@@ sv/irl_pkg.sv @@
// ----------------------------------------------------------------------------
// irl_pkg: shared types and constants for the IPv4 route lookup core
// Field widths, action codes, the transaction record that moves along the
// cell chain, and a mask bit-count helper.
// ----------------------------------------------------------------------------
`default_nettype none

package irl_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 16;

  // Field widths
  localparam int IDX_W  = 4;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int TTL_W  = 8;
  localparam int LEN_W  = 6;
  localparam int ACT_W  = 2;

  // Item kinds (carried on in_tuser)
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_ROUTE = 1'b1;

  // Result actions (carried on out_tuser)
  localparam logic [ACT_W-1:0] ACT_DISCARD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOCAL   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOROUTE = 2'd3;

  // One transaction travelling down the chain, with the best match so far
  typedef struct packed {
    logic              is_route;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_prefix;
    logic [ADDR_W-1:0] entry_mask;
    logic [LEN_W-1:0]  entry_len;
    logic [PORT_W-1:0] entry_port;
    logic              entry_is_local;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  nttl;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic              best_is_local;
    logic [PORT_W-1:0] best_port;
  } irl_item_t;

  // Ones in each nibble value
  localparam logic [2:0] NIB_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  // Number of one bits in a 32-bit mask, summed nibble by nibble
  function automatic logic [LEN_W-1:0] mask_ones(input logic [ADDR_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int k = 0; k < ADDR_W / 4; k++) begin
      n = n + LEN_W'(NIB_ONES[v[k*4 +: 4]]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/irl_cell.sv @@
// ----------------------------------------------------------------------------
// irl_cell: one route table slot in the lookup chain
// Holds a single route. A write transaction for this slot loads it; a route
// transaction compares its destination against it and takes it as the best
// match when the mask is at least as long. The transaction then moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module irl_cell
  import irl_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire logic      in_valid,
  input  wire irl_item_t in_item,
  output logic           out_valid,
  output irl_item_t      out_item
);

  // Stored route
  logic              ent_v_r;
  logic [ADDR_W-1:0] ent_prefix_r;
  logic [ADDR_W-1:0] ent_mask_r;
  logic [LEN_W-1:0]  ent_len_r;
  logic [PORT_W-1:0] ent_port_r;
  logic              ent_is_local_r;

  // Transaction stage
  logic      item_v_r;
  irl_item_t item_r;
  irl_item_t item_nxt;

  logic hit;
  logic match;

  // Write aimed at this slot
  assign hit = in_valid && (in_item.is_route == MODE_WRITE) &&
               (int'(in_item.entry_index) == CELL_IDX);

  // Prefix compare and best-match update; later slots win ties
  assign match = ent_v_r &&
                 (((ent_prefix_r ^ in_item.dest) & ent_mask_r) == '0);

  always_comb begin
    item_nxt = in_item;
    if ((in_item.is_route == MODE_ROUTE) && match &&
        (!in_item.found || (ent_len_r >= in_item.best_len))) begin
      item_nxt.found         = 1'b1;
      item_nxt.best_len      = ent_len_r;
      item_nxt.best_is_local = ent_is_local_r;
      item_nxt.best_port     = ent_port_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r  <= 1'b0;
      item_v_r <= 1'b0;
    end else if (adv) begin
      item_v_r <= in_valid;
      if (hit) begin
        ent_v_r <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
      if (hit) begin
        ent_prefix_r   <= in_item.entry_prefix;
        ent_mask_r     <= in_item.entry_mask;
        ent_len_r      <= in_item.entry_len;
        ent_port_r     <= in_item.entry_port;
        ent_is_local_r <= in_item.entry_is_local;
      end
    end
  end

  assign out_valid = item_v_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

@@ sv/ip_route_lookup_ttl_core.sv @@
// ----------------------------------------------------------------------------
// ip_route_lookup_ttl_core: IPv4 longest-prefix route lookup with TTL handling
//
// Input stream (in_*): in_tuser selects the transaction kind. A table write
// loads one route slot and returns nothing; a route transaction returns one
// result on the output stream (out_*) with the action on out_tuser.
// Transactions are taken on any cycle where in_tvalid and in_tready are high.
//
// The table is a chain of TABLE_ENTRIES cells, one route per cell. Every
// transaction walks the chain one cell per cycle while the chain advances,
// so writes and lookups keep their order. The chain registers it in each cell
// in turn, then in the output register; one transaction per cycle unless stalled.
//
// Reset clears every route valid bit and empties the chain. When the
// receiver stalls with a result pending, the whole chain holds and
// in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_route_lookup_ttl_core
  import irl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, low bit up: entry_index[3:0], entry_prefix[35:4],
  // entry_mask[67:36], entry_port[83:68], entry_local[84],
  // packet_dest[116:85], packet_ttl[124:117], zero fill[127:125]
  input  wire logic [127:0] in_tdata,
  // in_tuser: mode[0]
  input  wire logic         in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata, low bit up: out_port[15:0], new_ttl[23:16]
  output logic [23:0]       out_tdata,
  // out_tuser: action[1:0]
  output logic [ACT_W-1:0]  out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready
);

  logic      adv;
  irl_item_t head_item;
  logic [TTL_W-1:0] in_ttl;

  logic      chain_valid [TABLE_ENTRIES+1];
  irl_item_t chain_item  [TABLE_ENTRIES+1];

  logic              out_valid_r;
  logic [ACT_W-1:0]  out_act_r;
  logic [PORT_W-1:0] out_port_r;
  logic [TTL_W-1:0]  out_ttl_r;
  logic [ACT_W-1:0]  out_act_nxt;
  logic [PORT_W-1:0] out_port_nxt;

  // Chain advances unless a result is stuck at the output
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Unpack input transaction, count mask ones, decrement TTL
  assign in_ttl = in_tdata[124:117];

  always_comb begin
    head_item                = '0;
    head_item.is_route       = in_tuser;
    head_item.entry_index    = in_tdata[3:0];
    head_item.entry_prefix   = in_tdata[35:4];
    head_item.entry_mask     = in_tdata[67:36];
    head_item.entry_len      = mask_ones(in_tdata[67:36]);
    head_item.entry_port     = in_tdata[83:68];
    head_item.entry_is_local = in_tdata[84];
    head_item.dest           = in_tdata[116:85];
    head_item.nttl           = (in_ttl == '0) ? '0 : in_ttl - TTL_W'(1);
  end

  assign chain_valid[0] = in_tvalid;
  assign chain_item[0]  = head_item;

  // Route cell chain
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    irl_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (chain_valid[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  // Final decision from the best match
  always_comb begin
    out_port_nxt = '0;
    if (chain_item[TABLE_ENTRIES].nttl == '0) begin
      out_act_nxt = ACT_DISCARD;
    end else if (!chain_item[TABLE_ENTRIES].found) begin
      out_act_nxt = ACT_NOROUTE;
    end else if (chain_item[TABLE_ENTRIES].best_is_local) begin
      out_act_nxt = ACT_LOCAL;
    end else begin
      out_act_nxt  = ACT_FORWARD;
      out_port_nxt = chain_item[TABLE_ENTRIES].best_port;
    end
  end

  // Output register; table writes leave no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain_valid[TABLE_ENTRIES] &&
                     (chain_item[TABLE_ENTRIES].is_route == MODE_ROUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_act_r  <= out_act_nxt;
      out_port_r <= out_port_nxt;
      out_ttl_r  <= chain_item[TABLE_ENTRIES].nttl;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {out_ttl_r, out_port_r};

  // Checks
  a_port_only_on_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ACT_FORWARD)) |-> (out_tdata[15:0] == '0))
    else $error("nonzero port on a result that does not forward");

  a_discard_iff_ttl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ACT_DISCARD) == (out_tdata[23:16] == '0)))
    else $error("discard decision disagrees with new TTL");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ip_route_lookup_ttl_core
// Writes route slots and sends lookups over the input stream. A local model
// of the route table predicts the action, port and TTL of each lookup; a
// monitor compares every result in order. The run covers directed corner
// cases, random traffic under three idle profiles, and a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import irl_pkg::*;

  localparam int TBL_N    = TABLE_ENTRIES_DEF;
  localparam int HALF_PER = 4;

  // One input transaction, split into its fields
  typedef struct {
    logic              mode;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] prefix, mask;
    logic [PORT_W-1:0] port;
    logic              is_local;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  ttl;
  } fwd_req_t;

  // One lookup result
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PORT_W-1:0] port;
    logic [TTL_W-1:0]  ttl;
  } lookup_res_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic [127:0] in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [23:0]  out_tdata;
  logic [ACT_W-1:0] out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;

  // Route table as the bench sees it
  logic [ADDR_W-1:0] tbl_prefix [TBL_N];
  logic [ADDR_W-1:0] tbl_mask   [TBL_N];
  logic [PORT_W-1:0] tbl_port   [TBL_N];
  logic              tbl_local  [TBL_N];
  logic              tbl_valid  [TBL_N];

  lookup_res_t pending_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_request = 0;
  int hold_left = 0;
  int errors = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int act_count [4];
  int max_hold_seen = 0;
  int hold_run = 0;

  ip_route_lookup_ttl_core #(
    .TABLE_ENTRIES(TBL_N)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #HALF_PER clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: longest mask wins, higher slot wins a tie
  // ---------------------------------------------------------------------------
  function automatic lookup_res_t lookup_route(input logic [ADDR_W-1:0] dest,
                                               input logic [TTL_W-1:0] ttl);
    lookup_res_t r;
    logic        hit;
    int          best;
    int          best_len;
    int          len;
    r.ttl    = (ttl == '0) ? '0 : ttl - 8'd1;
    r.port   = '0;
    r.action = ACT_DISCARD;
    hit      = 1'b0;
    best     = 0;
    best_len = 0;
    if (r.ttl != '0) begin
      for (int i = 0; i < TBL_N; i++) begin
        if (tbl_valid[i] && (((tbl_prefix[i] ^ dest) & tbl_mask[i]) == '0)) begin
          len = $countones(tbl_mask[i]);
          if (!hit || len >= best_len) begin
            hit      = 1'b1;
            best_len = len;
            best     = i;
          end
        end
      end
      if (!hit) begin
        r.action = ACT_NOROUTE;
      end else if (tbl_local[best]) begin
        r.action = ACT_LOCAL;
      end else begin
        r.action = ACT_FORWARD;
        r.port   = tbl_port[best];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders for directed traffic; unused fields get random values
  // ---------------------------------------------------------------------------
  function automatic fwd_req_t mk_write(input logic [IDX_W-1:0] idx,
                                        input logic [ADDR_W-1:0] prefix,
                                        input logic [ADDR_W-1:0] mask,
                                        input logic [PORT_W-1:0] port,
                                        input logic is_local);
    fwd_req_t r;
    r.mode     = MODE_WRITE;
    r.idx      = idx;
    r.prefix   = prefix;
    r.mask     = mask;
    r.port     = port;
    r.is_local = is_local;
    r.dest     = $urandom;
    r.ttl      = TTL_W'($urandom);
    return r;
  endfunction

  function automatic fwd_req_t mk_route(input logic [ADDR_W-1:0] dest,
                                        input logic [TTL_W-1:0] ttl);
    fwd_req_t r;
    r.mode     = MODE_ROUTE;
    r.idx      = IDX_W'($urandom);
    r.prefix   = $urandom;
    r.mask     = $urandom;
    r.port     = PORT_W'($urandom);
    r.is_local = 1'($urandom);
    r.dest     = dest;
    r.ttl      = ttl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Send one transaction and update the predictor on acceptance
  // ---------------------------------------------------------------------------
  task automatic send_item(input fwd_req_t req);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.mode;
    in_tdata  <= {3'b000, req.ttl, req.dest, req.is_local, req.port,
                  req.mask, req.prefix, req.idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req.mode == MODE_WRITE) begin
      n_writes++;
      if (int'(req.idx) < TBL_N) begin
        tbl_prefix[req.idx] = req.prefix;
        tbl_mask[req.idx]   = req.mask;
        tbl_port[req.idx]   = req.port;
        tbl_local[req.idx]  = req.is_local;
        tbl_valid[req.idx]  = 1'b1;
      end
    end else begin
      n_lookups++;
      pending_q.push_back(lookup_route(req.dest, req.ttl));
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus long holds counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result action=%0d port=%h ttl=%0d",
                                  out_tuser, out_tdata[15:0], out_tdata[23:16]));
      end else begin
        want = pending_q.pop_front();
        act_count[out_tuser]++;
        if (out_tuser != want.action)
          report_mismatch($sformatf("action got %0d want %0d", out_tuser, want.action));
        if (out_tdata[15:0] != want.port)
          report_mismatch($sformatf("port got %h want %h", out_tdata[15:0], want.port));
        if (out_tdata[23:16] != want.ttl)
          report_mismatch($sformatf("ttl got %0d want %0d", out_tdata[23:16], want.ttl));
      end
    end
  end

  // Track how long the input was held off
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) begin
      hold_run = hold_run + 1;
      if (hold_run > max_hold_seen) begin
        max_hold_seen = hold_run;
      end
    end else begin
      hold_run = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // First route; lookups carry junk entry fields
    send_item(mk_write(4'd0, 32'h0A00_0000, 32'hFF00_0000, 16'h1111, 1'b0));
    send_item(mk_route(32'h0A01_0203, 8'd255));
    // TTL already zero, TTL that reaches zero, smallest TTL that survives
    send_item(mk_route(32'h0A01_0203, 8'd0));
    send_item(mk_route(32'h0A01_0203, 8'd1));
    send_item(mk_route(32'h0A01_0203, 8'd2));
    // No route
    send_item(mk_route(32'h0B00_0001, 8'd64));
    // Loopback host route delivers locally
    send_item(mk_write(4'd15, 32'h7F00_0001, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_item(mk_route(32'h7F00_0001, 8'd64));
    // Default route catches everything else
    send_item(mk_write(4'd3, 32'h0000_0000, 32'h0000_0000, 16'hABCD, 1'b0));
    send_item(mk_route(32'h0B00_0001, 8'd64));
    // Equal mask length: higher slot wins, even if written first
    send_item(mk_write(4'd5, 32'h0A00_0000, 32'hFF00_0000, 16'h2222, 1'b0));
    send_item(mk_route(32'h0A09_0909, 8'd10));
    send_item(mk_write(4'd1, 32'h0AFF_FFFF, 32'hFF00_0000, 16'h3333, 1'b0));
    send_item(mk_route(32'h0A09_0909, 8'd10));
    // Longer mask in a lower slot beats a shorter one higher up
    send_item(mk_write(4'd2, 32'h0A01_0000, 32'hFFFF_0000, 16'h4444, 1'b0));
    send_item(mk_route(32'h0A01_0505, 8'd10));
    // Non-contiguous mask entry; this lookup misses it and takes the default route
    send_item(mk_write(4'd7, 32'hC0A8_00FF, 32'hF0F0_F0F0, 16'h5555, 1'b0));
    send_item(mk_route(32'hC5AB_0C0D, 8'd10));
    // Overwrite a slot with local delivery
    send_item(mk_write(4'd5, 32'h0A00_0000, 32'hFF00_0000, 16'h6666, 1'b1));
    send_item(mk_route(32'h0AC8_0001, 8'd100));
    // All-ones prefix and mask with port zero
    send_item(mk_write(4'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0));
    send_item(mk_route(32'hFFFF_FFFF, 8'd128));
    send_item(mk_route(32'h0000_0000, 8'd3));
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    fwd_req_t         r;
    int               k;
    int               len;
    int               pick;
    logic [ADDR_W-1:0] noise;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      r.idx      = IDX_W'($urandom);
      r.prefix   = $urandom;
      r.port     = PORT_W'($urandom);
      r.is_local = ($urandom_range(99) < 20);
      r.dest     = $urandom;
      r.ttl      = TTL_W'($urandom);
      r.mask     = $urandom;
      if ($urandom_range(99) < 25) begin
        r.mode = MODE_WRITE;
        pick   = $urandom_range(99);
        if (pick < 70) begin
          len = $urandom_range(32);
          r.mask = ~({ADDR_W{1'b1}} >> len);
        end else if (pick < 90) begin
          len = 8 * $urandom_range(4);
          r.mask = ~({ADDR_W{1'b1}} >> len);
        end
      end else begin
        r.mode = MODE_ROUTE;
        // Mostly aim at a stored prefix so lookups hit something
        if ($urandom_range(99) < 75) begin
          k      = $urandom_range(TBL_N - 1);
          noise  = $urandom;
          r.dest = (tbl_prefix[k] & tbl_mask[k]) | (noise & ~tbl_mask[k]);
        end
        pick = $urandom_range(99);
        if (pick < 8)       r.ttl = 8'd0;
        else if (pick < 16) r.ttl = 8'd1;
        else if (pick < 21) r.ttl = 8'd255;
        else                r.ttl = TTL_W'($urandom_range(255, 2));
      end
      send_item(r);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    stall_request = 120;
    for (int n = 0; n < 50; n++) begin
      send_item(mk_route($urandom, TTL_W'($urandom_range(255, 2))));
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TBL_N + 4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TBL_N; i++) begin
      tbl_prefix[i] = '0;
      tbl_mask[i]   = '0;
      tbl_port[i]   = '0;
      tbl_local[i]  = 1'b0;
      tbl_valid[i]  = 1'b0;
    end
    for (int i = 0; i < 4; i++) act_count[i] = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(400, 34, 62);
    test_random(400, 62, 34);
    test_random(300, 0, 0);
    test_backpressure();
    drain_results();

    while (pending_q.size() != 0) begin
      void'(pending_q.pop_front());
      report_mismatch("lookup result never arrived");
    end
    $display("Ran %0d table writes and %0d lookups, including a 120-cycle output stall.",
             n_writes, n_lookups);
    $display("Results seen: discard %0d, local %0d, forward %0d, no route %0d; %s %0d.",
             act_count[ACT_DISCARD], act_count[ACT_LOCAL],
             act_count[ACT_FORWARD], act_count[ACT_NOROUTE],
             "longest input hold", max_hold_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d lookups outstanding", pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
